// File: rtl/tdf_pkg.sv
`timescale 1ns / 1ps

package tdf_pkg;

   // Default width of the number to factor, in bits.
   localparam int WIDTH_DEFAULT = 64;

   // Width of a stream data bus that carries a field of the given width,
   // rounded up to whole bytes.
   function automatic int bus_width(input int field_width);
      return ((field_width + 7) / 8) * 8;
   endfunction

endpackage

// File: rtl/trial_division_factorizer_unit.sv
`timescale 1ns / 1ps

// Trial-division prime factorizer.
//
// The req_ stream carries one number to factor per item. The rsp_ stream returns
// its prime factors in nondecreasing order, one factor per item, followed by the
// remaining cofactor, which is 1 for a power of two or for an input of one.
// rsp_tlast marks the final item for a number. An input of zero gives a single
// item with value 0, rsp_tlast set and the zero-error flag in rsp_tuser set.
//
// One number is worked on at a time; req_tready is high only while the unit is
// idle. Each factor of two is stripped by a shift. Every trial of an odd divisor
// takes WIDTH steps of the shared restoring divider, which yields both the
// quotient and the remainder, and one decision step. The number of
// trials is data dependent: the divisor climbs to the larger of the second largest
// prime factor and the square root of the largest, so a large prime takes far longer.
//
// The result sits in an output register. While the receiver stalls, the unit
// holds at the point where it wants to emit its next item and resumes as soon
// as the register frees up. Synchronous reset returns the unit to idle and
// drops any result not yet taken.

module trial_division_factorizer_unit #(
   parameter int WIDTH = tdf_pkg::WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Number to factor.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [tdf_pkg::bus_width(WIDTH)-1:0]   req_tdata,   // number
   // Factors.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [tdf_pkg::bus_width(WIDTH)-1:0]   rsp_tdata,   // factor_value
   output logic                                   rsp_tlast,   // last_factor
   output logic                                   rsp_tuser    // zero_error
);

   localparam int BUS_W = tdf_pkg::bus_width(WIDTH);
   // A trial divisor never exceeds the square root of the cofactor, plus two.
   localparam int DIV_W = (WIDTH + 1) / 2 + 1;
   localparam int CNT_W = $clog2(WIDTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_DECIDE
   } state_type;

   state_type              state_ff, state_in;
   logic [WIDTH-1:0]       cofactor_ff, cofactor_in;
   logic [DIV_W-1:0]       divisor_ff, divisor_in;
   logic [DIV_W-1:0]       rem_ff, rem_in;
   logic [WIDTH-1:0]       quo_ff, quo_in;
   logic [CNT_W-1:0]       step_ff, step_in;
   logic                   out_valid_ff, out_valid_in;
   logic [WIDTH-1:0]       out_value_ff, out_value_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_err_ff, out_err_in;

   logic                   out_free;
   logic [DIV_W:0]         trial_rem;
   logic [DIV_W:0]         trial_diff;
   logic                   trial_fits;
   logic [WIDTH-1:0]       divisor_wide;

   // The output register can take a new item when it is empty or being drained.
   assign out_free = !out_valid_ff || rsp_tready;

   // One step of the restoring divider: bring down the next dividend bit and
   // subtract the divisor when it fits.
   assign trial_rem    = {rem_ff, quo_ff[WIDTH-1]};
   assign trial_diff   = trial_rem - {1'b0, divisor_ff};
   assign trial_fits   = (trial_rem >= {1'b0, divisor_ff});
   assign divisor_wide = WIDTH'(divisor_ff);

   always_comb begin
      state_in     = state_ff;
      cofactor_in  = cofactor_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cofactor_in = req_tdata[WIDTH-1:0];
               divisor_in  = DIV_W'(3);
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cofactor_ff == '0) begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_value_in = '0;
                  out_last_in  = 1'b1;
                  out_err_in   = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (!cofactor_ff[0]) begin
               // Strip one factor of two per cycle while the output register is free.
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_value_in = WIDTH'(2);
                  out_last_in  = 1'b0;
                  out_err_in   = 1'b0;
                  cofactor_in  = cofactor_ff >> 1;
               end
            end else begin
               rem_in   = '0;
               quo_in   = cofactor_ff;
               step_in  = CNT_W'(WIDTH - 1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = trial_fits ? trial_diff[DIV_W-1:0] : trial_rem[DIV_W-1:0];
            quo_in  = {quo_ff[WIDTH-2:0], trial_fits};
            step_in = step_ff - CNT_W'(1);
            if (step_ff == '0) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // The divisor exceeds the quotient exactly when its square exceeds
            // the cofactor, so what remains is prime or 1.
            if (divisor_wide > quo_ff) begin
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_value_in = cofactor_ff;
                  out_last_in  = 1'b1;
                  out_err_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else if (rem_ff == '0) begin
               // The divisor divides: emit it and try it again on the quotient.
               if (out_free) begin
                  out_valid_in = 1'b1;
                  out_value_in = divisor_wide;
                  out_last_in  = 1'b0;
                  out_err_in   = 1'b0;
                  cofactor_in  = quo_ff;
                  rem_in       = '0;
                  step_in      = CNT_W'(WIDTH - 1);
                  state_in     = ST_DIVIDE;
               end
            end else begin
               divisor_in = divisor_ff + DIV_W'(2);
               rem_in     = '0;
               quo_in     = cofactor_ff;
               step_in    = CNT_W'(WIDTH - 1);
               state_in   = ST_DIVIDE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         divisor_ff   <= DIV_W'(3);
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         divisor_ff   <= divisor_in;
      end
      cofactor_ff  <= cofactor_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = BUS_W'(out_value_ff);
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

   // A zero-error item is always the only and last item, with value zero.
   a_zero_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (out_value_ff == '0))
      else $error("zero-error item without last flag or with nonzero value");

   // Trial divisors stay odd, so even factors only come from the strip phase.
   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      divisor_ff[0])
      else $error("trial divisor became even");

   // After the divide steps the remainder is below the divisor.
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE |-> rem_ff < divisor_ff)
      else $error("divider remainder not reduced");

   // An accepted number keeps the unit busy in the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && (state_ff == ST_CHECK))
      else $error("unit not busy after accepting a number");

   // Once the odd divisors are tried the cofactor is odd and nonzero.
   a_cofactor_odd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE || state_ff == ST_DECIDE |-> cofactor_ff[0])
      else $error("cofactor even during trial division");

endmodule
